>>> sv/racc_pkg.sv
// ----------------------------------------------------------------------------
// racc_pkg
// shared constants, types and word helpers for the rational accumulator
// ----------------------------------------------------------------------------
package racc_pkg;

   localparam int WORD_BITS = 32;
   localparam int FIELD_BITS = 32;
   localparam int CNT_BITS = $clog2(WORD_BITS);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [CNT_BITS-1:0] count_type;

   localparam logic [2:0] MODE_LOAD    = 3'd0;
   localparam logic [2:0] MODE_ADD     = 3'd1;
   localparam logic [2:0] MODE_SUB     = 3'd2;
   localparam logic [2:0] MODE_MUL_NUM = 3'd3;
   localparam logic [2:0] MODE_MUL_DEN = 3'd4;

   typedef struct packed {
      logic busy;
      logic done;
   } serial_status_type;

   function automatic word_type neg_word(input word_type v);
      return word_type'(-v);
   endfunction

   function automatic word_type abs_word(input word_type v);
      return v[WORD_BITS-1] ? neg_word(v) : v;
   endfunction

   function automatic word_type to_word(input logic [FIELD_BITS-1:0] v);
      logic signed [63:0] t;
      t = 64'(signed'(v));
      return t[WORD_BITS-1:0];
   endfunction

   function automatic logic [FIELD_BITS-1:0] from_word(input word_type v);
      logic signed [63:0] t;
      t = 64'(signed'(v));
      return t[FIELD_BITS-1:0];
   endfunction

endpackage

>>> sv/racc_mul.sv
// ----------------------------------------------------------------------------
// racc_mul
// bit-serial shift-add multiplier, product modulo 2^WORD_BITS
// ----------------------------------------------------------------------------
module racc_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  racc_pkg::word_type         mcand,
   input  racc_pkg::word_type         mplier,
   output racc_pkg::word_type         product,
   output racc_pkg::serial_status_type status
);

   racc_pkg::word_type  a_ff, a_in;
   racc_pkg::word_type  b_ff, b_in;
   racc_pkg::word_type  acc_ff, acc_in;
   racc_pkg::count_type cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = mcand;
         b_in    = mplier;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[racc_pkg::WORD_BITS-2:0], 1'b0};
         b_in   = {1'b0, b_ff[racc_pkg::WORD_BITS-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == racc_pkg::CNT_BITS'(racc_pkg::WORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> sv/racc_div.sv
// ----------------------------------------------------------------------------
// racc_div
// bit-serial restoring divider on unsigned magnitudes, quotient and remainder
// ----------------------------------------------------------------------------
module racc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  racc_pkg::word_type         dividend,
   input  racc_pkg::word_type         divisor,
   output racc_pkg::word_type         quotient,
   output racc_pkg::word_type         remainder,
   output racc_pkg::serial_status_type status
);

   racc_pkg::word_type              q_ff, q_in;
   racc_pkg::word_type              d_ff, d_in;
   racc_pkg::word_type              r_ff, r_in;
   racc_pkg::count_type             cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [racc_pkg::WORD_BITS:0]    r_shift;
   logic [racc_pkg::WORD_BITS:0]    r_diff;

   assign r_shift = {r_ff, q_ff[racc_pkg::WORD_BITS-1]};
   assign r_diff  = r_shift - {1'b0, d_ff};

   always_comb begin
      q_in    = q_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         d_in    = divisor;
         r_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (r_diff[racc_pkg::WORD_BITS]) begin
            r_in = r_shift[racc_pkg::WORD_BITS-1:0];
            q_in = {q_ff[racc_pkg::WORD_BITS-2:0], 1'b0};
         end else begin
            r_in = r_diff[racc_pkg::WORD_BITS-1:0];
            q_in = {q_ff[racc_pkg::WORD_BITS-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == racc_pkg::CNT_BITS'(racc_pkg::WORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = q_ff;
   assign remainder   = r_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> sv/rational_accumulator_reduce_unit.sv
// ----------------------------------------------------------------------------
// rational_accumulator_reduce_unit
// holds one fraction, applies one operation per beat, reduces it by its gcd
// ----------------------------------------------------------------------------
// One item is taken at a time. Add, subtract and both multiply modes run a
// bit-serial multiply first; a load or an unused mode skips it. Reduction
// then runs Euclid on a bit-serial divider, one division per Euclid step,
// and then divides the numerator and the denominator by the gcd. A single
// divider is shared by the Euclid steps and both final divisions. A finished
// result waits in an output register, so the next item is accepted while it
// is pending.
module rational_accumulator_reduce_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_operand,
   input  logic [31:0] req_load_denominator,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_numerator_out,
   output logic [31:0] rsp_denominator_out,
   output logic        rsp_zero_gcd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_EUC  = 7'b0000100,
      ST_EDIV = 7'b0001000,
      ST_QNUM = 7'b0010000,
      ST_QDEN = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         mode_ff, mode_in;
   racc_pkg::word_type numer_ff, numer_in;
   racc_pkg::word_type denom_ff, denom_in;
   racc_pkg::word_type x_ff, x_in;
   racc_pkg::word_type y_ff, y_in;
   logic               zero_ff, zero_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_num_ff, rsp_num_in;
   logic [31:0]        rsp_den_ff, rsp_den_in;
   logic               rsp_zero_ff, rsp_zero_in;

   logic                        req_fire;
   logic                        mul_start;
   racc_pkg::word_type          mul_b;
   racc_pkg::word_type          mul_prod;
   racc_pkg::serial_status_type mul_stat;
   logic                        div_start;
   racc_pkg::word_type          div_a;
   racc_pkg::word_type          div_b;
   racc_pkg::word_type          div_q;
   racc_pkg::word_type          div_r;
   racc_pkg::serial_status_type div_stat;
   racc_pkg::word_type          div_q_signed;
   racc_pkg::word_type          op_n;
   racc_pkg::word_type          op_d;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign mul_start = req_fire && (req_mode == racc_pkg::MODE_ADD ||
      req_mode == racc_pkg::MODE_SUB || req_mode == racc_pkg::MODE_MUL_NUM ||
      req_mode == racc_pkg::MODE_MUL_DEN);
   assign mul_b = (req_mode == racc_pkg::MODE_MUL_NUM) ? numer_ff : denom_ff;

   racc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (racc_pkg::to_word(req_operand)),
      .mplier  (mul_b),
      .product (mul_prod),
      .status  (mul_stat)
   );

   always_comb begin
      priority if (state_ff == ST_EUC && y_ff != '0) begin
         div_a = racc_pkg::abs_word(x_ff);
         div_b = racc_pkg::abs_word(y_ff);
      end else if (state_ff == ST_EUC) begin
         div_a = racc_pkg::abs_word(numer_ff);
         div_b = racc_pkg::abs_word(x_ff);
      end else begin
         div_a = racc_pkg::abs_word(denom_ff);
         div_b = racc_pkg::abs_word(x_ff);
      end
   end

   assign div_start = (state_ff == ST_EUC && (y_ff != '0 || x_ff != '0)) ||
                      (state_ff == ST_QNUM && div_stat.done);

   racc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .quotient  (div_q),
      .remainder (div_r),
      .status    (div_stat)
   );

   // quotient sign follows the operand being divided and the gcd
   always_comb begin
      if (state_ff == ST_QNUM) begin
         div_q_signed = (numer_ff[racc_pkg::WORD_BITS-1] ^ x_ff[racc_pkg::WORD_BITS-1])
                        ? racc_pkg::neg_word(div_q) : div_q;
      end else begin
         div_q_signed = (denom_ff[racc_pkg::WORD_BITS-1] ^ x_ff[racc_pkg::WORD_BITS-1])
                        ? racc_pkg::neg_word(div_q) : div_q;
      end
   end

   always_comb begin
      op_n = numer_ff;
      op_d = denom_ff;
      unique case (mode_ff)
         racc_pkg::MODE_ADD:     op_n = numer_ff + mul_prod;
         racc_pkg::MODE_SUB:     op_n = numer_ff - mul_prod;
         racc_pkg::MODE_MUL_NUM: op_n = mul_prod;
         default:                op_d = mul_prod;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      numer_in     = numer_ff;
      denom_in     = denom_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_zero_in  = rsp_zero_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_mode;
               unique case (req_mode)
                  racc_pkg::MODE_LOAD: begin
                     numer_in = racc_pkg::to_word(req_operand);
                     denom_in = racc_pkg::to_word(req_load_denominator);
                     x_in     = racc_pkg::to_word(req_operand);
                     y_in     = racc_pkg::to_word(req_load_denominator);
                     state_in = ST_EUC;
                  end
                  racc_pkg::MODE_ADD, racc_pkg::MODE_SUB,
                  racc_pkg::MODE_MUL_NUM, racc_pkg::MODE_MUL_DEN: begin
                     state_in = ST_MUL;
                  end
                  default: begin
                     x_in     = numer_ff;
                     y_in     = denom_ff;
                     state_in = ST_EUC;
                  end
               endcase
            end
         end
         ST_MUL: begin
            if (mul_stat.done) begin
               numer_in = op_n;
               denom_in = op_d;
               x_in     = op_n;
               y_in     = op_d;
               state_in = ST_EUC;
            end
         end
         ST_EUC: begin
            if (y_ff != '0) begin
               state_in = ST_EDIV;
            end else if (x_ff == '0) begin
               zero_in  = 1'b1;
               state_in = ST_FIN;
            end else begin
               zero_in  = 1'b0;
               state_in = ST_QNUM;
            end
         end
         ST_EDIV: begin
            if (div_stat.done) begin
               x_in     = y_ff;
               y_in     = x_ff[racc_pkg::WORD_BITS-1] ? racc_pkg::neg_word(div_r) : div_r;
               state_in = ST_EUC;
            end
         end
         ST_QNUM: begin
            if (div_stat.done) begin
               numer_in = div_q_signed;
               state_in = ST_QDEN;
            end
         end
         ST_QDEN: begin
            if (div_stat.done) begin
               denom_in = div_q_signed;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = racc_pkg::from_word(numer_ff);
               rsp_den_in   = racc_pkg::from_word(denom_ff);
               rsp_zero_in  = zero_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      zero_ff     <= zero_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_den_ff  <= rsp_den_in;
      rsp_zero_ff <= rsp_zero_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         numer_ff     <= '0;
         denom_ff     <= racc_pkg::word_type'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         numer_ff     <= numer_in;
         denom_ff     <= denom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_numerator_out   = rsp_num_ff;
   assign rsp_denominator_out = rsp_den_ff;
   assign rsp_zero_gcd        = rsp_zero_ff;

`ifndef SYNTHESIS
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_mul_div_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy))
      else $error("multiplier and divider busy together");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_gcd) |-> (rsp_numerator_out == '0 && rsp_denominator_out == '0))
      else $error("zero gcd beat with nonzero fraction");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_MUL || state_ff == ST_EUC))
      else $error("accepted beat did not start work");
`endif

endmodule
